// File: hdl/iqagc_pkg.sv
// Shared types and constants for the IQ AGC with squelch.
// Used by the register bank, the controller, the datapath and the top level.
// No dependencies.
package iqagc_pkg;

  localparam int LEVEL_W   = 34;  // unsigned Q18.16 level
  localparam int COEF_W    = 24;  // unsigned Q0.24 smoothing weight
  localparam int SCALE_W   = 18;
  localparam int GAIN_W    = 10;
  localparam int SAMPLE_W  = 16;  // signed Q1.15
  localparam int OUT_W     = 32;  // signed Q15.16
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = LEVEL_W;
  localparam int HALF_W    = 17;  // half of the level difference, one multiplier pass each
  localparam int PROD_W    = HALF_W + COEF_W;
  localparam int NUM_W     = SAMPLE_W + GAIN_W;
  localparam int QUO_W     = 32;
  localparam int CNT_W     = $clog2(QUO_W);

  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_COEF   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_COEF    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SQUELCH_LEVEL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_SCALE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_GAIN   = 3'd4;

  localparam logic [COEF_W-1:0]  ATTACK_RESET  = 24'd167772;
  localparam logic [COEF_W-1:0]  DECAY_RESET   = 24'd1678;
  localparam logic [LEVEL_W-1:0] SQUELCH_RESET = 34'd0;
  localparam logic [SCALE_W-1:0] SCALE_RESET   = 18'd100000;
  localparam logic [GAIN_W-1:0]  GAIN_RESET    = 10'd100;
  localparam logic [LEVEL_W-1:0] LEVEL_RESET   = 34'd655360;

  localparam logic [OUT_W-1:0] OUT_POS_SAT = 32'h7FFF_FFFF;
  localparam logic [OUT_W-1:0] OUT_NEG_SAT = 32'h8000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TARGET,
    ST_DIFF,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_DELTA,
    ST_LEVEL,
    ST_NUMER,
    ST_DIV_INIT,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic target;
    logic diff;
    logic mul_lo;
    logic mul_hi;
    logic delta;
    logic level_upd;
    logic numer;
    logic div_init;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [COEF_W-1:0]  attack_coef;
    logic [COEF_W-1:0]  decay_coef;
    logic [LEVEL_W-1:0] squelch_level;
    logic [SCALE_W-1:0] level_scale;
    logic [GAIN_W-1:0]  output_gain;
  } cfg_t;

endpackage

// File: hdl/iqagc_regs.sv
// Configuration register bank for the IQ AGC with squelch.
// Depends on iqagc_pkg.
module iqagc_regs import iqagc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.attack_coef   <= ATTACK_RESET;
      cfg.decay_coef    <= DECAY_RESET;
      cfg.squelch_level <= SQUELCH_RESET;
      cfg.level_scale   <= SCALE_RESET;
      cfg.output_gain   <= GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ATTACK_COEF:   cfg.attack_coef   <= cfg_data[COEF_W-1:0];
        REG_DECAY_COEF:    cfg.decay_coef    <= cfg_data[COEF_W-1:0];
        REG_SQUELCH_LEVEL: cfg.squelch_level <= cfg_data[LEVEL_W-1:0];
        REG_LEVEL_SCALE:   cfg.level_scale   <= cfg_data[SCALE_W-1:0];
        REG_OUTPUT_GAIN:   cfg.output_gain   <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: hdl/iqagc_ctrl.sv
// Sequencing state machine for the IQ AGC with squelch.
// Depends on iqagc_pkg; drives the datapath through cmd_t.
module iqagc_ctrl import iqagc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output cmd_t cmd
);

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             out_valid_next;
  logic             out_free;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (in_valid) state_next = ST_TARGET;
      ST_TARGET:   state_next = ST_DIFF;
      ST_DIFF:     state_next = ST_MUL_LO;
      ST_MUL_LO:   state_next = ST_MUL_HI;
      ST_MUL_HI:   state_next = ST_DELTA;
      ST_DELTA:    state_next = ST_LEVEL;
      ST_LEVEL:    state_next = ST_NUMER;
      ST_NUMER:    state_next = ST_DIV_INIT;
      ST_DIV_INIT: state_next = ST_DIV;
      ST_DIV:      if (cnt == CNT_W'(QUO_W - 1)) state_next = ST_DONE;
      ST_DONE:     if (out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    in_stall       = 1'b1;
    cnt_next       = cnt;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_TARGET:   cmd.target    = 1'b1;
      ST_DIFF:     cmd.diff      = 1'b1;
      ST_MUL_LO:   cmd.mul_lo    = 1'b1;
      ST_MUL_HI:   cmd.mul_hi    = 1'b1;
      ST_DELTA:    cmd.delta     = 1'b1;
      ST_LEVEL:    cmd.level_upd = 1'b1;
      ST_NUMER:    cmd.numer     = 1'b1;
      ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        cnt_next     = '0;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
      end
      ST_DONE:     cmd.out_load  = out_free;
      default: ;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

// File: hdl/iqagc_dp.sv
// Datapath of the IQ AGC with squelch: level tracking, gain numerators,
// two bit-serial dividers and the output register. Depends on iqagc_pkg.
module iqagc_dp import iqagc_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  cmd_t                       cmd,
  input  cfg_t                       cfg,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic signed [SAMPLE_W-1:0] sample_q,
  output logic signed [OUT_W-1:0]    out_i,
  output logic signed [OUT_W-1:0]    out_q,
  output logic [LEVEL_W-1:0]         current_level,
  output logic                       squelched
);

  logic [SAMPLE_W-1:0]  si, sq;
  logic [SAMPLE_W-1:0]  mag_i, mag_q;
  logic [LEVEL_W-1:0]   level;
  logic [LEVEL_W-1:0]   target;
  logic [COEF_W-1:0]    coef;
  logic [LEVEL_W-1:0]   diff;
  logic                 up;
  logic [PROD_W-1:0]    p_lo, p_hi;
  logic [LEVEL_W-1:0]   delta;
  logic [NUM_W-1:0]     num_i, num_q;
  logic [LEVEL_W-1:0]   rem_i, rem_q;
  logic [QUO_W-1:0]     dq_i, dq_q;
  logic                 ovf_i, ovf_q;
  logic                 pass;

  logic [LEVEL_W:0]     target_full;
  logic                 attack;
  logic [HALF_W-1:0]    mul_a;
  logic [PROD_W-1:0]    mul_p;
  logic [PROD_W+HALF_W:0] delta_sum;
  logic [LEVEL_W+QUO_W-1:0] step_i, step_q;
  logic [LEVEL_W-1:0]   top_i, top_q;

  function automatic logic [SAMPLE_W-1:0] abs16(input logic [SAMPLE_W-1:0] x);
    abs16 = x[SAMPLE_W-1] ? (~x + 1'b1) : x;
  endfunction

  // One restoring division step: shift in the next dividend bit, subtract if it fits,
  // shift the quotient bit into the vacated low end of the dividend register.
  function automatic logic [LEVEL_W+QUO_W-1:0] div_bit(input logic [LEVEL_W-1:0] rem,
                                                        input logic [QUO_W-1:0]   dq,
                                                        input logic [LEVEL_W-1:0] lvl);
    logic [LEVEL_W:0] t;
    logic [LEVEL_W:0] s;
    t = {rem, dq[QUO_W-1]};
    s = t - {1'b0, lvl};
    if (t >= {1'b0, lvl}) begin
      div_bit = {s[LEVEL_W-1:0], dq[QUO_W-2:0], 1'b1};
    end else begin
      div_bit = {t[LEVEL_W-1:0], dq[QUO_W-2:0], 1'b0};
    end
  endfunction

  function automatic logic [OUT_W-1:0] fmt(input logic neg, input logic zero_mag,
                                            input logic ovf, input logic [QUO_W-1:0] q);
    if (zero_mag) begin
      fmt = '0;
    end else if (neg) begin
      fmt = (ovf || q > OUT_NEG_SAT) ? OUT_NEG_SAT : (~q + 1'b1);
    end else begin
      fmt = (ovf || q[QUO_W-1]) ? OUT_POS_SAT : q;
    end
  endfunction

  assign mag_i = abs16(si);
  assign mag_q = abs16(sq);

  assign target_full = {LEVEL_W'(mag_i) * LEVEL_W'(cfg.level_scale), 1'b0};
  // A negative I sample never counts as exceeding the level.
  assign attack = !si[SAMPLE_W-1] && ({{(LEVEL_W-SAMPLE_W-1){1'b0}}, si, 1'b0} > level);

  // One shared multiplier, low half of the difference first.
  assign mul_a = cmd.mul_hi ? diff[LEVEL_W-1:HALF_W] : diff[HALF_W-1:0];
  assign mul_p = PROD_W'(mul_a) * PROD_W'(coef);

  assign delta_sum = {p_hi, {HALF_W{1'b0}}} + {{(HALF_W+1){1'b0}}, p_lo};

  // Dividend is num << 17; its bits above 2^32 form the starting remainder.
  assign top_i = {{(LEVEL_W-(NUM_W-15)){1'b0}}, num_i[NUM_W-1:15]};
  assign top_q = {{(LEVEL_W-(NUM_W-15)){1'b0}}, num_q[NUM_W-1:15]};

  assign step_i = div_bit(rem_i, dq_i, level);
  assign step_q = div_bit(rem_q, dq_q, level);

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= LEVEL_RESET;
    end else if (cmd.level_upd) begin
      level <= up ? (level + delta) : (level - delta);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      si <= sample_i;
      sq <= sample_q;
    end
    if (cmd.target) begin
      target <= target_full[LEVEL_W-1:0];
      coef   <= attack ? cfg.attack_coef : cfg.decay_coef;
    end
    if (cmd.diff) begin
      up   <= target >= level;
      diff <= (target >= level) ? (target - level) : (level - target);
    end
    if (cmd.mul_lo) p_lo <= mul_p;
    if (cmd.mul_hi) p_hi <= mul_p;
    if (cmd.delta)  delta <= delta_sum[PROD_W+HALF_W-1:COEF_W];
    if (cmd.numer) begin
      num_i <= NUM_W'(mag_i) * NUM_W'(cfg.output_gain);
      num_q <= NUM_W'(mag_q) * NUM_W'(cfg.output_gain);
    end
    if (cmd.div_init) begin
      rem_i <= top_i;
      rem_q <= top_q;
      dq_i  <= {num_i[14:0], {(QUO_W-15){1'b0}}};
      dq_q  <= {num_q[14:0], {(QUO_W-15){1'b0}}};
      // Quotient of 2^32 or more, or a zero level, saturates.
      ovf_i <= top_i >= level;
      ovf_q <= top_q >= level;
      pass  <= level >= cfg.squelch_level;
    end else if (cmd.div_step) begin
      {rem_i, dq_i} <= step_i;
      {rem_q, dq_q} <= step_q;
    end
    if (cmd.out_load) begin
      out_i         <= pass ? fmt(si[SAMPLE_W-1], mag_i == '0, ovf_i, dq_i) : '0;
      out_q         <= pass ? fmt(sq[SAMPLE_W-1], mag_q == '0, ovf_q, dq_q) : '0;
      current_level <= level;
      squelched     <= !pass;
    end
  end

endmodule

// File: hdl/iq_agc_with_squelch_core.sv
// IQ automatic gain control with squelch: top level.
// Depends on iqagc_pkg, iqagc_regs, iqagc_ctrl and iqagc_dp.
//
// Each transaction on the input takes one complex sample. After the accepting edge the controller steps
// through the level update (one shared 17x24 multiplier used twice) and the gain numerators, loads
// the dividers, runs the two bit-serial dividers that scale I and Q by gain/level, one quotient bit
// per cycle each, and loads the output register, which raises out_valid; it then returns to idle,
// where the next sample is accepted, so a new sample is taken only once the last result is loaded.
// The result sits in an output register, so the next sample is accepted while a finished result
// still waits on out_stall; a later result that finds the register still full waits in its last step.
// Configuration registers take effect for the next sample; they are to be written only while no
// sample is in flight, which the block itself does not enforce.
module iq_agc_with_squelch_core import iqagc_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic signed [SAMPLE_W-1:0] sample_q,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [OUT_W-1:0]    out_i,
  output logic signed [OUT_W-1:0]    out_q,
  output logic [LEVEL_W-1:0]         current_level,
  output logic                       squelched
);

  cfg_t cfg;
  cmd_t cmd;

  iqagc_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  iqagc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  iqagc_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cfg           (cfg),
    .sample_i      (sample_i),
    .sample_q      (sample_q),
    .out_i         (out_i),
    .out_q         (out_q),
    .current_level (current_level),
    .squelched     (squelched)
  );

  // Only one sample is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while a sample was in flight");

  a_squelch_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && squelched) |-> (out_i == '0 && out_q == '0))
    else $error("squelched result carries nonzero samples");

  a_no_squelch_at_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && cfg.squelch_level == '0) |-> !squelched)
    else $error("squelch flagged with a zero threshold");

endmodule

// File: tb/iq_agc_with_squelch_core_tb.sv
// Self-checking testbench for the IQ AGC with squelch core.
// Runs a directed table and then random phases with idling and back-pressure on both channels.
// Depends on iqagc_pkg and iq_agc_with_squelch_core.
module iq_agc_with_squelch_core_tb;
  import iqagc_pkg::*;

  localparam int NUM_PHASES     = 8;
  localparam int PHASE_ITEMS    = 142;
  localparam int PRESSURE_PHASE = 5;
  localparam int HOLD_CYCLES    = 600;
  localparam int SETTLE_CYCLES  = 4;
  localparam int TAIL_CYCLES    = 60;
  localparam longint unsigned LEVEL_MASK = (64'd1 << LEVEL_W) - 1;
  // Indexes past the end of the register list; writes to them must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;
  localparam int TX_IDLE_PCT[4] = '{0, 50, 0, 19};
  localparam int RX_STALL_PCT[4] = '{0, 0, 50, 19};
  localparam int AMP_SHIFT[4] = '{0, 3, 7, 11};

  typedef struct packed {
    logic signed [OUT_W-1:0] out_i;
    logic signed [OUT_W-1:0] out_q;
    logic [LEVEL_W-1:0]      level;
    logic                    squelched;
  } agc_result_t;

  typedef enum bit {ROW_WRITE, ROW_SAMPLE} row_kind_t;

  typedef struct packed {
    row_kind_t                   kind;
    logic [CFG_IDX_W-1:0]        idx;
    logic [CFG_W-1:0]            data;
    logic signed [SAMPLE_W-1:0]  si;
    logic signed [SAMPLE_W-1:0]  sq;
    logic                        typed;
    agc_result_t                 res;
  } stim_row_t;

  logic                       clk;
  logic                       rst;
  logic                       cfg_we;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_W-1:0]           cfg_data;
  logic                       in_valid;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] sample_i;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [OUT_W-1:0]    out_i;
  logic signed [OUT_W-1:0]    out_q;
  logic [LEVEL_W-1:0]         current_level;
  logic                       squelched;

  // Predictor copy of the registers and the tracked level.
  longint unsigned agc_attack, agc_decay, agc_squelch, agc_scale, agc_gain, agc_level;

  agc_result_t pending_outputs[$];
  stim_row_t   directed_rows[$];

  int  errors = 0;
  int  samples_sent = 0;
  int  results_seen = 0;
  int  squelched_seen = 0;
  int  saturated_seen = 0;
  int  tx_pct = 0;
  int  rx_pct = 0;
  int  hold_left = 0;
  bit  hold_req = 1'b0;
  bit  hold_served = 1'b0;
  agc_result_t want;

  iq_agc_with_squelch_core dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sample_i(sample_i),
    .sample_q(sample_q),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_i(out_i),
    .out_q(out_q),
    .current_level(current_level),
    .squelched(squelched)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Timeout with %0d results still outstanding", pending_outputs.size());
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [OUT_W-1:0] scale_by_gain(input longint x, input longint unsigned lvl);
    longint unsigned quo;
    if (x == 0) return '0;
    if (lvl == 0) return (x < 0) ? OUT_NEG_SAT : OUT_POS_SAT;
    quo = longint'(x < 0 ? -x : x) * agc_gain * 64'd131072 / lvl;
    if (x < 0) return (quo > 64'h8000_0000) ? OUT_NEG_SAT : OUT_W'(64'd0 - quo);
    return (quo > 64'h7FFF_FFFF) ? OUT_POS_SAT : OUT_W'(quo);
  endfunction

  // Advances the tracked level by one sample and forms the gain-normalized outputs.
  function automatic agc_result_t next_agc_output(input logic signed [SAMPLE_W-1:0] si,
                                                  input logic signed [SAMPLE_W-1:0] sq);
    longint ix, qx;
    longint unsigned lvl, target, coef;
    agc_result_t r;
    ix = si;
    qx = sq;
    lvl = agc_level;
    target = 2 * longint'(ix < 0 ? -ix : ix) * agc_scale;
    // A negative sample never counts as being above the level.
    coef = (2 * ix > longint'(lvl)) ? agc_attack : agc_decay;
    if (target >= lvl) lvl = lvl + (((target - lvl) * coef) >> 24);
    else lvl = lvl - (((lvl - target) * coef) >> 24);
    lvl = lvl & LEVEL_MASK;
    agc_level = lvl;
    r.level = LEVEL_W'(lvl);
    if (lvl >= agc_squelch) begin
      r.out_i = scale_by_gain(ix, lvl);
      r.out_q = scale_by_gain(qx, lvl);
      r.squelched = 1'b0;
    end else begin
      r.out_i = '0;
      r.out_q = '0;
      r.squelched = 1'b1;
    end
    return r;
  endfunction

  function automatic void add_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    stim_row_t row;
    row = '0;
    row.kind = ROW_WRITE;
    row.idx = idx;
    row.data = data;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_sample(input logic signed [SAMPLE_W-1:0] si,
                                     input logic signed [SAMPLE_W-1:0] sq);
    stim_row_t row;
    row = '0;
    row.kind = ROW_SAMPLE;
    row.si = si;
    row.sq = sq;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_known(input logic signed [SAMPLE_W-1:0] si,
                                    input logic signed [SAMPLE_W-1:0] sq,
                                    input logic [OUT_W-1:0] oi, input logic [OUT_W-1:0] oq,
                                    input logic [LEVEL_W-1:0] lvl, input logic sql);
    stim_row_t row;
    row = '0;
    row.kind = ROW_SAMPLE;
    row.si = si;
    row.sq = sq;
    row.typed = 1'b1;
    row.res.out_i = oi;
    row.res.out_q = oq;
    row.res.level = lvl;
    row.res.squelched = sql;
    directed_rows.push_back(row);
  endfunction

  function automatic void check_field(input string field, input longint exp_val,
                                      input longint act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, exp_val, act_val);
      errors++;
    end
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_ATTACK_COEF:   agc_attack = data[COEF_W-1:0];
      REG_DECAY_COEF:    agc_decay = data[COEF_W-1:0];
      REG_SQUELCH_LEVEL: agc_squelch = data[LEVEL_W-1:0];
      REG_LEVEL_SCALE:   agc_scale = data[SCALE_W-1:0];
      REG_OUTPUT_GAIN:   agc_gain = data[GAIN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] si,
                             input logic signed [SAMPLE_W-1:0] sq,
                             input logic typed, input agc_result_t known);
    agc_result_t pred;
    while ($urandom_range(99) < tx_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_i <= si;
    sample_q <= sq;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = next_agc_output(si, sq);
    pending_outputs.push_back(typed ? known : pred);
    samples_sent++;
  endtask

  // Lowers valid and waits until every outstanding transaction has produced its result.
  task automatic drain_results(input int extra);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // Receiver: random stalls, plus one long hold-off that backs the block up.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_req && !hold_served) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_served <= 1'b1;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_outputs.size() == 0) begin
        $display("%0t: unexpected result: out_i=%0d out_q=%0d level=%0d squelched=%0b",
                 $time, out_i, out_q, current_level, squelched);
        errors++;
      end else begin
        want = pending_outputs.pop_front();
        check_field("out_i", longint'(want.out_i), longint'(out_i));
        check_field("out_q", longint'(want.out_q), longint'(out_q));
        check_field("current_level", longint'(want.level), longint'(current_level));
        check_field("squelched", longint'(want.squelched), longint'(squelched));
        results_seen++;
        if (squelched) squelched_seen++;
        if (out_i == OUT_POS_SAT || out_i == OUT_NEG_SAT) saturated_seen++;
      end
    end
  end

  initial begin
    stim_row_t row;
    int sh;
    int r;
    logic signed [SAMPLE_W-1:0] si, sq;
    logic [SCALE_W-1:0] scale;

    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_ATTACK_COEF;
    cfg_data <= '0;
    in_valid <= 1'b0;
    sample_i <= '0;
    sample_q <= '0;
    agc_attack = ATTACK_RESET;
    agc_decay = DECAY_RESET;
    agc_squelch = SQUELCH_RESET;
    agc_scale = SCALE_RESET;
    agc_gain = GAIN_RESET;
    agc_level = LEVEL_RESET;

    // Zero sample from reset: the level decays from 10.0 by one decay step.
    add_known(16'sd0, 16'sd0, '0, '0, 34'd655295, 1'b0);
    // With both weights at zero the level is frozen.
    add_write(REG_ATTACK_COEF, 34'd0);
    add_write(REG_DECAY_COEF, 34'd0);
    add_sample(16'sd32767, -16'sd32768);
    add_sample(-16'sd32768, 16'sd32767);
    // Gain written with junk above its width masks down to zero.
    add_write(REG_OUTPUT_GAIN, 34'h3_FFFF_FC00);
    add_known(16'sd12345, -16'sd12345, '0, '0, 34'd655295, 1'b0);
    add_write(REG_UNUSED_LO, 34'h3_FFFF_FFFF);
    add_write(REG_UNUSED_HI, 34'h1_2345_6789);
    add_write(REG_OUTPUT_GAIN, 34'd1023);
    add_write(REG_LEVEL_SCALE, 34'd0);
    add_write(REG_ATTACK_COEF, 34'hFF_FFFF);
    add_write(REG_DECAY_COEF, 34'hFF_FFFF);
    // Zero target with full weight drops the level to its floor of one LSB.
    add_known(16'sd100, -16'sd32768, OUT_POS_SAT, OUT_NEG_SAT, 34'd1, 1'b0);
    add_known(16'sd0, 16'sd32767, '0, OUT_POS_SAT, 34'd1, 1'b0);
    add_sample(16'sd1, -16'sd1);
    add_write(REG_SQUELCH_LEVEL, 34'd2);
    add_known(-16'sd32768, 16'sd32767, '0, '0, 34'd1, 1'b1);
    add_write(REG_SQUELCH_LEVEL, 34'h3_FFFF_FFFF);
    add_known(16'sd32767, 16'sd32767, '0, '0, 34'd1, 1'b1);
    // Level equal to the threshold is not squelched.
    add_write(REG_SQUELCH_LEVEL, 34'd1);
    add_sample(-16'sd1, 16'sd1);
    add_write(REG_LEVEL_SCALE, 34'd262143);
    add_sample(-16'sd32768, 16'sd0);
    add_sample(16'sd32767, -16'sd32768);
    add_sample(-16'sd32768, -16'sd32768);
    add_write(REG_ATTACK_COEF, 34'd1);
    add_write(REG_DECAY_COEF, 34'h80_0000);
    add_write(REG_LEVEL_SCALE, 34'h3_C000_0005);
    add_write(REG_SQUELCH_LEVEL, 34'd0);
    add_sample(16'sd12000, -16'sd7000);
    add_sample(-16'sd20000, 16'sd32767);
    add_sample(16'sd0, -16'sd1);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[n]) begin
      row = directed_rows[n];
      if (row.kind == ROW_WRITE) begin
        drain_results(SETTLE_CYCLES);
        write_reg(row.idx, row.data);
      end else begin
        send_sample(row.si, row.sq, row.typed, row.res);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results(SETTLE_CYCLES);
      case (p)
        0: begin
          write_reg(REG_ATTACK_COEF, 34'(ATTACK_RESET));
          write_reg(REG_DECAY_COEF, 34'(DECAY_RESET));
          write_reg(REG_SQUELCH_LEVEL, SQUELCH_RESET);
          write_reg(REG_LEVEL_SCALE, 34'(SCALE_RESET));
          write_reg(REG_OUTPUT_GAIN, 34'(GAIN_RESET));
        end
        1: begin
          write_reg(REG_ATTACK_COEF, 34'hFF_FFFF);
          write_reg(REG_DECAY_COEF, 34'hFF_FFFF);
          write_reg(REG_SQUELCH_LEVEL, 34'd0);
          write_reg(REG_LEVEL_SCALE, 34'd262143);
          write_reg(REG_OUTPUT_GAIN, 34'd1023);
        end
        2: begin
          write_reg(REG_ATTACK_COEF, 34'd1);
          write_reg(REG_DECAY_COEF, 34'd0);
          write_reg(REG_SQUELCH_LEVEL, 34'd0);
          write_reg(REG_LEVEL_SCALE, 34'd1);
          write_reg(REG_OUTPUT_GAIN, 34'd1);
        end
        default: begin
          scale = SCALE_W'($urandom_range(1, 262143));
          write_reg(REG_ATTACK_COEF, 34'($urandom_range(0, 24'hFF_FFFF) >> $urandom_range(0, 12)));
          write_reg(REG_DECAY_COEF, 34'($urandom_range(0, 24'hFF_FFFF) >> $urandom_range(4, 20)));
          // Threshold spread around the typical level so squelch opens and closes.
          write_reg(REG_SQUELCH_LEVEL, 34'((64'($urandom) * scale) >> 16));
          write_reg(REG_LEVEL_SCALE, 34'(scale));
          write_reg(REG_OUTPUT_GAIN, 34'($urandom_range(1, 1023)));
        end
      endcase
      tx_pct = TX_IDLE_PCT[p % 4];
      rx_pct = RX_STALL_PCT[p % 4];
      if (p == PRESSURE_PHASE) hold_req <= 1'b1;
      sh = 0;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // Runs of one amplitude let the level settle, then swing across the threshold.
        if (k % 16 == 0) sh = AMP_SHIFT[$urandom_range(3)];
        si = SAMPLE_W'($urandom);
        sq = SAMPLE_W'($urandom);
        si = si >>> sh;
        sq = sq >>> sh;
        r = $urandom_range(99);
        if (r < 5) begin
          case ($urandom_range(3))
            0: si = 16'sh8000;
            1: si = 16'sh7FFF;
            2: si = 16'sd0;
            default: si = -16'sd1;
          endcase
        end
        send_sample(si, sq, 1'b0, '0);
      end
    end

    drain_results(TAIL_CYCLES);
    $display("Sent %0d samples (directed table, then %0d random phases with idling and a %0d-cycle",
             samples_sent, NUM_PHASES, HOLD_CYCLES);
    $display("output hold-off); %0d results checked, %0d squelched, %0d with saturated I, %0d errors.",
             results_seen, squelched_seen, saturated_seen, errors);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/iqagc_pkg.sv
hdl/iqagc_regs.sv
hdl/iqagc_ctrl.sv
hdl/iqagc_dp.sv
hdl/iq_agc_with_squelch_core.sv
tb/iq_agc_with_squelch_core_tb.sv
